// ===== src/dwpi_pkg.sv =====
// Shared constants, types and register codes for the dual-wheel PI speed controller.
package dwpi_pkg;

	localparam int GAIN_FRAC_BITS = 8;
	localparam int SUM_WIDTH      = 32;

	localparam int POS_W   = 16;
	localparam int TGT_W   = 8;
	localparam int ERR_W   = POS_W + 1;
	localparam int GAIN_W  = 12;
	localparam int LIMIT_W = 10;
	localparam int DUTY_W  = LIMIT_W - 1;
	localparam int DRV_W   = SUM_WIDTH + GAIN_W + 2;
	localparam int CLAMP_W = LIMIT_W + 1;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KP_LEFT   = 8'd0,
		REG_KP_RIGHT  = 8'd1,
		REG_KI_T      = 8'd2,
		REG_OUT_LIMIT = 8'd3
	} reg_index_t;

	localparam logic [GAIN_W-1:0]  KP_LEFT_RST   = 12'd847;
	localparam logic [GAIN_W-1:0]  KP_RIGHT_RST  = 12'd863;
	localparam logic [GAIN_W-1:0]  KI_T_RST      = 12'd64;
	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 10'd1023;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp_left;
		logic [GAIN_W-1:0]  kp_right;
		logic [GAIN_W-1:0]  ki_t;
		logic [LIMIT_W-1:0] out_limit;
	} cfg_t;

endpackage

// ===== src/dwpi_if.sv =====
// Valid/ready channel interfaces: tick input, drive output and register writes.
interface dwpi_tick_if;
	import dwpi_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [POS_W-1:0]        left_position;
	logic [POS_W-1:0]        right_position;
	logic signed [TGT_W-1:0] left_target;
	logic signed [TGT_W-1:0] right_target;
	modport source(output valid, left_position, right_position, left_target, right_target,
		input ready);
	modport sink(input valid, left_position, right_position, left_target, right_target,
		output ready);
endinterface

interface dwpi_duty_if;
	import dwpi_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] left_duty;
	logic              left_forward;
	logic [DUTY_W-1:0] right_duty;
	logic              right_forward;
	modport source(output valid, left_duty, left_forward, right_duty, right_forward,
		input ready);
	modport sink(input valid, left_duty, left_forward, right_duty, right_forward,
		output ready);
endinterface

interface dwpi_cfg_if;
	import dwpi_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/dwpi_cfg_regs.sv =====
// Gain and limit registers written through the configuration channel.
module dwpi_cfg_regs
	import dwpi_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	dwpi_cfg_if.sink        cfg,
	output cfg_t            regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp_left   <= KP_LEFT_RST;
			regs_q.kp_right  <= KP_RIGHT_RST;
			regs_q.ki_t      <= KI_T_RST;
			regs_q.out_limit <= OUT_LIMIT_RST;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_KP_LEFT:   regs_q.kp_left   <= cfg.data[GAIN_W-1:0];
				REG_KP_RIGHT:  regs_q.kp_right  <= cfg.data[GAIN_W-1:0];
				REG_KI_T:      regs_q.ki_t      <= cfg.data[GAIN_W-1:0];
				REG_OUT_LIMIT: regs_q.out_limit <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/dwpi_integrator.sv =====
// Per-wheel speed measurement, speed error and saturating error integrator.
module dwpi_integrator
	import dwpi_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [POS_W-1:0]            position,
	input  logic signed [TGT_W-1:0]     target,
	output logic signed [ERR_W-1:0]     err_s2,
	output logic signed [SUM_WIDTH-1:0] sum_s2
);

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic [POS_W-1:0]            last_pos_q;
	logic signed [SUM_WIDTH-1:0] sum_q;

	logic signed [POS_W-1:0]     speed;
	logic signed [ERR_W-1:0]     err;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_next;

	always_comb begin
		speed    = $signed(position - last_pos_q);
		err      = ERR_W'(target) - ERR_W'(speed);
		sum_wide = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(err);
		// top two bits disagree: the add ran past the signed range
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
			sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		else
			sum_next = sum_wide[SUM_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			sum_q      <= '0;
		end else if (advance) begin
			last_pos_q <= position;
			sum_q      <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			err_s2 <= err;
			sum_s2 <= sum_next;
		end
	end

endmodule

// ===== src/dwpi_drive.sv =====
// Per-wheel PI drive: two products, Q scaling toward zero, clamp, halving to duty.
module dwpi_drive
	import dwpi_pkg::*;
(
	input  logic [GAIN_W-1:0]           kp,
	input  logic [GAIN_W-1:0]           ki_t,
	input  logic [LIMIT_W-1:0]          out_limit,
	input  logic signed [ERR_W-1:0]     err,
	input  logic signed [SUM_WIDTH-1:0] sum,
	output logic [DUTY_W-1:0]           duty,
	output logic                        forward
);

	localparam logic signed [DRV_W-1:0] ROUND_BIAS = DRV_W'((1 << GAIN_FRAC_BITS) - 1);

	logic signed [DRV_W-1:0]   p_term;
	logic signed [DRV_W-1:0]   i_term;
	logic signed [DRV_W-1:0]   drive;
	logic signed [DRV_W-1:0]   scaled;
	logic signed [DRV_W-1:0]   lim;
	logic signed [CLAMP_W-1:0] clamped;
	logic [LIMIT_W-1:0]        mag;

	always_comb begin
		// operands widened first so the products are formed at full width
		p_term = DRV_W'($signed({1'b0, kp})) * DRV_W'(err);
		i_term = DRV_W'($signed({1'b0, ki_t})) * DRV_W'(sum);
		drive  = p_term + i_term;
		// shift toward zero: bias negatives before the arithmetic shift
		scaled = (drive[DRV_W-1] ? drive + ROUND_BIAS : drive) >>> GAIN_FRAC_BITS;
		lim    = DRV_W'($signed({1'b0, out_limit}));
		if (scaled > lim)
			clamped = CLAMP_W'(lim);
		else if (scaled < -lim)
			clamped = CLAMP_W'(-lim);
		else
			clamped = CLAMP_W'(scaled);
		mag     = clamped[CLAMP_W-1] ? LIMIT_W'(-clamped) : clamped[LIMIT_W-1:0];
		duty    = mag[LIMIT_W-1:1];
		forward = !clamped[CLAMP_W-1] && (mag[LIMIT_W-1:1] != '0);
	end

endmodule

// ===== src/dual_wheel_pi_speed_control.sv =====
// Top level of the dual-wheel PI speed controller.
// A tick beat accepted into the stage 1 register passes through the integrator register and
//   the result register. Throughput: one tick per cycle while the receiver takes duty beats;
//   the result register lets a new tick in while a result waits.
// Reset (arst_n low, asynchronous): gains and limit to defaults, positions and integrators
//   to zero, pipeline emptied; no clearing pass.
module dual_wheel_pi_speed_control
	import dwpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dwpi_tick_if.sink  tick,
	dwpi_duty_if.source duty,
	dwpi_cfg_if.sink   cfg
);

	cfg_t regs;

	// stage 1: captured tick beat
	logic                    valid_s1;
	logic [POS_W-1:0]        left_pos_s1;
	logic [POS_W-1:0]        right_pos_s1;
	logic signed [TGT_W-1:0] left_tgt_s1;
	logic signed [TGT_W-1:0] right_tgt_s1;

	// stage 2: errors and updated integrators
	logic                        valid_s2;
	logic signed [ERR_W-1:0]     left_err_s2;
	logic signed [ERR_W-1:0]     right_err_s2;
	logic signed [SUM_WIDTH-1:0] left_sum_s2;
	logic signed [SUM_WIDTH-1:0] right_sum_s2;

	// result register
	logic              out_valid_q;
	logic [DUTY_W-1:0] left_duty_q;
	logic              left_fwd_q;
	logic [DUTY_W-1:0] right_duty_q;
	logic              right_fwd_q;

	logic [DUTY_W-1:0] left_duty_d;
	logic              left_fwd_d;
	logic [DUTY_W-1:0] right_duty_d;
	logic              right_fwd_d;

	logic load_out;
	logic en_s2;
	logic en_s1;
	logic adv_s1;

	// Each stage moves on when the one after it is empty or moving on too.
	assign load_out = valid_s2 && (!out_valid_q || duty.ready);
	assign en_s2    = !valid_s2 || load_out;
	assign en_s1    = !valid_s1 || en_s2;
	// integrator state updates exactly when an item leaves stage 1
	assign adv_s1   = valid_s1 && en_s2;

	assign tick.ready = en_s1;

	dwpi_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= tick.valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (duty.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && tick.valid) begin
			left_pos_s1  <= tick.left_position;
			right_pos_s1 <= tick.right_position;
			left_tgt_s1  <= tick.left_target;
			right_tgt_s1 <= tick.right_target;
		end
	end

	dwpi_integrator u_left_int (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv_s1),
		.position (left_pos_s1),
		.target   (left_tgt_s1),
		.err_s2   (left_err_s2),
		.sum_s2   (left_sum_s2)
	);

	dwpi_integrator u_right_int (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv_s1),
		.position (right_pos_s1),
		.target   (right_tgt_s1),
		.err_s2   (right_err_s2),
		.sum_s2   (right_sum_s2)
	);

	dwpi_drive u_left_drv (
		.kp        (regs.kp_left),
		.ki_t      (regs.ki_t),
		.out_limit (regs.out_limit),
		.err       (left_err_s2),
		.sum       (left_sum_s2),
		.duty      (left_duty_d),
		.forward   (left_fwd_d)
	);

	dwpi_drive u_right_drv (
		.kp        (regs.kp_right),
		.ki_t      (regs.ki_t),
		.out_limit (regs.out_limit),
		.err       (right_err_s2),
		.sum       (right_sum_s2),
		.duty      (right_duty_d),
		.forward   (right_fwd_d)
	);

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_duty_q  <= left_duty_d;
			left_fwd_q   <= left_fwd_d;
			right_duty_q <= right_duty_d;
			right_fwd_q  <= right_fwd_d;
		end
	end

	assign duty.valid         = out_valid_q;
	assign duty.left_duty     = left_duty_q;
	assign duty.left_forward  = left_fwd_q;
	assign duty.right_duty    = right_duty_q;
	assign duty.right_forward = right_fwd_q;

endmodule

// ===== src/dwpi_checker.sv =====
// Port-level assertions for the speed controller, bound to the top level.
module dwpi_checker
	import dwpi_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              tick_valid,
	input logic              tick_ready,
	input logic              duty_valid,
	input logic              duty_ready,
	input logic [DUTY_W-1:0] left_duty,
	input logic              left_forward,
	input logic [DUTY_W-1:0] right_duty,
	input logic              right_forward
);

	logic [2:0] inflight_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = tick_valid && tick_ready;
	assign out_beat = duty_valid && duty_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid && !duty_ready |=> duty_valid && $stable(left_duty) && $stable(right_duty)
			&& $stable(left_forward) && $stable(right_forward))
		else $error("duty beat changed while stalled");

	a_fwd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid |-> !(left_forward && left_duty == '0) && !(right_forward && right_duty == '0))
		else $error("forward set with zero duty");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid |-> inflight_q != 3'd0)
		else $error("duty beat without a pending tick");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3 && (duty_valid || tick_ready))
		else $error("pipeline over-full or stalled with empty output");

endmodule

bind dual_wheel_pi_speed_control dwpi_checker u_dwpi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_valid    (tick.valid),
	.tick_ready    (tick.ready),
	.duty_valid    (duty.valid),
	.duty_ready    (duty.ready),
	.left_duty     (duty.left_duty),
	.left_forward  (duty.left_forward),
	.right_duty    (duty.right_duty),
	.right_forward (duty.right_forward)
);

// ===== bench/tb_dual_wheel_pi_speed_control.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the dual-wheel PI speed controller: tick driver, duty monitor, predictor.
module tb_dual_wheel_pi_speed_control;
	import dwpi_pkg::*;

	// Run shape
	localparam int  ROAD_TICKS  = 210;     // random ticks per road phase, one road phase on six of the settings
	localparam int  SAT_TICKS   = 40;      // sustained full-scale error, winds the integrators up
	localparam int  UNWIND      = 20;      // opposite error afterwards, sums must come back down
	localparam int  LONG_STALL  = 80;      // receiver hold-off, well past the pipeline depth
	localparam int  FINAL_TAIL  = 12;      // settle time after the final idle wait
	localparam int  CYCLE_LIMIT = 200000;  // watchdog bound on the run length
	localparam int  PRINT_CAP   = 40;

	localparam longint SUM_MAX = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
	localparam longint SUM_MIN = -SUM_MAX - 64'sd1;
	localparam longint Q_ONE   = 64'sd1 <<< GAIN_FRAC_BITS;

	// Register indexes past the map; writes to these must leave every register alone
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

	// Receiver back-pressure patterns
	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

	typedef struct {
		logic [POS_W-1:0]        left_position;
		logic [POS_W-1:0]        right_position;
		logic signed [TGT_W-1:0] left_target;
		logic signed [TGT_W-1:0] right_target;
	} tick_beat_t;

	typedef struct {
		logic [DUTY_W-1:0] left_duty;
		logic              left_forward;
		logic [DUTY_W-1:0] right_duty;
		logic              right_forward;
	} duty_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	dwpi_tick_if tick_ch();
	dwpi_duty_if duty_ch();
	dwpi_cfg_if  cfg_ch();

	dual_wheel_pi_speed_control dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.duty   (duty_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: index 0 is the left wheel, 1 the right
	// ------------------------------------------------------------------
	logic [POS_W-1:0]   last_pos [2];
	longint             err_sum [2];
	logic [GAIN_W-1:0]  kp_gain [2];
	logic [GAIN_W-1:0]  ki_gain;
	logic [LIMIT_W-1:0] drive_limit;

	tick_beat_t pending_ticks [$];   // built by the sequence, drained by the driver
	duty_beat_t expected_duty [$];   // one entry per accepted tick beat

	int ticks_offered = 0;
	int ticks_taken   = 0;
	int duty_beats    = 0;
	int regs_written  = 0;
	int settings_used = 0;
	int sum_pinned    = 0;
	int mismatch_count = 0;
	int cycle_count   = 0;

	// Sender idling
	int gap_left     = 0;
	int burst_left   = 0;
	bit tick_gapless = 1'b0;

	// Receiver idling
	rx_pattern_t rx_mode = RX_OPEN;
	int rx_left       = 0;
	int stall_left    = 0;
	int stalls_asked  = 0;
	int stalls_served = 0;

	// Sequence-side position tracking, so steps are given as speeds
	logic [POS_W-1:0] gen_lpos = '0;
	logic [POS_W-1:0] gen_rpos = '0;
	int road_left  = 0;
	int road_right = 0;

	task automatic note_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] duty beat %0d: %s got %0d want %0d", $realtime, duty_beats, what,
				got, want);
		mismatch_count++;
	endtask

	// One wheel of the controller: updates that wheel's last position and integrator,
	// returns the clamped drive already halved toward zero.
	function automatic longint wheel_drive(input int w, input logic [POS_W-1:0] pos,
		input logic signed [TGT_W-1:0] target);
		logic [POS_W-1:0] delta;
		longint speed, err, acc, drive, kp_l, ki_l, lim;
		delta = pos - last_pos[w];
		speed = $signed(delta);     // wrapped difference read as two's complement
		last_pos[w] = pos;
		err = target - speed;
		acc = err_sum[w] + err;
		if (acc > SUM_MAX) begin
			acc = SUM_MAX;
			sum_pinned++;
		end else if (acc < SUM_MIN) begin
			acc = SUM_MIN;
			sum_pinned++;
		end
		err_sum[w] = acc;
		// gains are unsigned; widen them on their own so the products stay signed
		kp_l = kp_gain[w];
		ki_l = ki_gain;
		lim  = drive_limit;
		drive = (kp_l * err + ki_l * acc) / Q_ONE;   // SV division truncates toward zero
		if (drive > lim)
			drive = lim;
		if (drive < -lim)
			drive = -lim;
		return drive / 2;
	endfunction

	// ------------------------------------------------------------------
	// Tick driver: unless gapless, bursts of random length, random gaps after each burst
	// ------------------------------------------------------------------
	always @(negedge clk) begin : tick_driver
		tick_beat_t beat;
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
		end else if (ticks_offered == ticks_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				tick_ch.valid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				beat = pending_ticks.pop_front();
				tick_ch.valid          <= 1'b1;
				tick_ch.left_position  <= beat.left_position;
				tick_ch.right_position <= beat.right_position;
				tick_ch.left_target    <= beat.left_target;
				tick_ch.right_target   <= beat.right_target;
				ticks_offered++;
				if (!tick_gapless) begin
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left   = $urandom_range(1, 9);
					end
				end
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Accepted tick beats feed the predictor straight away
	always @(posedge clk) begin : tick_watch
		longint     l_drv, r_drv;
		duty_beat_t want;
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			ticks_taken++;
			l_drv = wheel_drive(0, tick_ch.left_position, tick_ch.left_target);
			r_drv = wheel_drive(1, tick_ch.right_position, tick_ch.right_target);
			want.left_duty     = DUTY_W'((l_drv < 0) ? -l_drv : l_drv);
			want.left_forward  = (l_drv > 0);
			want.right_duty    = DUTY_W'((r_drv < 0) ? -r_drv : r_drv);
			want.right_forward = (r_drv > 0);
			expected_duty.push_back(want);
		end
	end

	// Register writes land in the predictor copy on the same beat
	always @(posedge clk) begin : cfg_watch
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			regs_written++;
			case (cfg_ch.index)
				REG_KP_LEFT:   kp_gain[0]  = cfg_ch.data[GAIN_W-1:0];
				REG_KP_RIGHT:  kp_gain[1]  = cfg_ch.data[GAIN_W-1:0];
				REG_KI_T:      ki_gain     = cfg_ch.data[GAIN_W-1:0];
				REG_OUT_LIMIT: drive_limit = cfg_ch.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Duty receiver: own stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin : duty_receiver
		if (stall_left > 0) begin
			stall_left--;
			duty_ch.ready <= 1'b0;
		end else if (stalls_served < stalls_asked) begin
			stalls_served++;
			stall_left = LONG_STALL - 1;
			duty_ch.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_pattern_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 160);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   duty_ch.ready <= 1'b1;
				RX_HALF:   duty_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: duty_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   duty_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Each duty beat is checked against the oldest prediction
	always @(posedge clk) begin : duty_watch
		duty_beat_t want;
		if (arst_n && duty_ch.valid && duty_ch.ready) begin
			duty_beats++;
			if (expected_duty.size() == 0) begin
				note_mismatch("unexpected beat, left_duty", duty_ch.left_duty, -1);
			end else begin
				want = expected_duty.pop_front();
				if (duty_ch.left_duty !== want.left_duty)
					note_mismatch("left_duty", duty_ch.left_duty, want.left_duty);
				if (duty_ch.left_forward !== want.left_forward)
					note_mismatch("left_forward", duty_ch.left_forward, want.left_forward);
				if (duty_ch.right_duty !== want.right_duty)
					note_mismatch("right_duty", duty_ch.right_duty, want.right_duty);
				if (duty_ch.right_forward !== want.right_forward)
					note_mismatch("right_forward", duty_ch.right_forward, want.right_forward);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers
	// ------------------------------------------------------------------
	task automatic queue_tick(input logic [POS_W-1:0] lp, input logic [POS_W-1:0] rp,
		input logic signed [TGT_W-1:0] lt, input logic signed [TGT_W-1:0] rt);
		tick_beat_t beat;
		beat.left_position  = lp;
		beat.right_position = rp;
		beat.left_target    = lt;
		beat.right_target   = rt;
		pending_ticks.push_back(beat);
		gen_lpos = lp;
		gen_rpos = rp;
	endtask

	// Move each wheel by the given counts (wrapping) and set the targets
	task automatic queue_step(input int dl, input int dr, input int lt, input int rt);
		queue_tick(gen_lpos + dl[POS_W-1:0], gen_rpos + dr[POS_W-1:0], lt[TGT_W-1:0],
			rt[TGT_W-1:0]);
	endtask

	// Mostly small tracking error, now and then a harder shove
	function automatic int wobble();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom_range(0, 80)) - 40;
		return int'($urandom_range(0, 6)) - 3;
	endfunction

	// Driving-like ticks: wheels follow their targets with some wobble; one in ten beats
	// is pure noise and one in ten changes the targets.
	task automatic queue_road_ticks(input int count);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				queue_tick(POS_W'($urandom), POS_W'($urandom), TGT_W'($urandom),
					TGT_W'($urandom));
			end else begin
				if (kind == 1) begin
					road_left  = int'($urandom_range(0, 255)) - 128;
					road_right = int'($urandom_range(0, 255)) - 128;
				end
				queue_step(road_left + wobble(), road_right + wobble(), road_left, road_right);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_sel,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_sel;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_gains(input logic [CFG_DATA_W-1:0] kp_l, input logic [CFG_DATA_W-1:0] kp_r,
		input logic [CFG_DATA_W-1:0] ki, input logic [CFG_DATA_W-1:0] lim);
		write_reg(REG_KP_LEFT, kp_l);
		write_reg(REG_KP_RIGHT, kp_r);
		write_reg(REG_KI_T, ki);
		write_reg(REG_OUT_LIMIT, lim);
		settings_used++;
	endtask

	// Sender holds back until every queued tick is taken and every duty beat is back
	task automatic wait_idle();
		while (pending_ticks.size() != 0 || ticks_offered != ticks_taken ||
			expected_duty.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.left_position  = '0;
		tick_ch.right_position = '0;
		tick_ch.left_target    = '0;
		tick_ch.right_target   = '0;
		duty_ch.ready = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = REG_KP_LEFT;
		cfg_ch.data   = '0;
		last_pos[0] = '0;
		last_pos[1] = '0;
		err_sum[0]  = 0;
		err_sum[1]  = 0;
		kp_gain[0]  = KP_LEFT_RST;
		kp_gain[1]  = KP_RIGHT_RST;
		ki_gain     = KI_T_RST;
		drive_limit = OUT_LIMIT_RST;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset gains. First tick is measured against a last position of zero, then
		// full-scale speeds both ways with extreme targets, and a zero-error step.
		queue_tick(16'h1234, 16'hFFFF, 0, 0);
		queue_step(-32768, 32767, 127, -128);
		queue_step(-32768, 32767, -128, 127);
		queue_tick(16'h0000, 16'hFFFF, 127, 127);
		queue_tick(16'hFFFF, 16'h0000, -128, -128);
		queue_step(5, -5, 5, -5);
		queue_step(0, 0, 0, 0);
		wait_idle();

		// All gains zero: drive is nil whatever the error
		load_gains(0, 0, 0, 1023);
		queue_step(100, -100, 0, 0);
		wait_idle();

		// Unit kp, no integral: drive of +-1 halves to nothing, +-2 and +-3 to one
		load_gains(1, 1, 0, 1023);
		queue_step(-256, 256, 0, 0);
		queue_step(-512, 512, 0, 0);
		queue_step(-768, 768, 0, 0);
		wait_idle();

		// Limit written with bits above its width set, lands as zero
		load_gains(847, 863, 64, 12'hC00);
		queue_step(300, -300, 0, 0);
		queue_step(0, 0, 127, -128);
		wait_idle();

		// Limit masked to full scale, then writes past the register map that would alias
		// onto kp_left and out_limit if the index were only partly decoded
		load_gains(847, 863, 64, 12'hFFF);
		write_reg(REG_UNUSED_LOW, 12'h000);
		write_reg(REG_UNUSED_TOP, 12'h000);
		queue_step(-300, 300, 0, 0);
		queue_step(-40, 40, 10, -10);
		queue_step(7, -7, 0, 0);
		wait_idle();

		// Everything at the top
		load_gains(4095, 4095, 4095, 1023);
		queue_step(1, -1, 0, 0);
		queue_step(-32768, 32767, 127, -128);
		queue_step(0, 0, 0, 0);
		wait_idle();

		// Lopsided gains, limit of one: clamped drive halves to nothing
		load_gains(4095, 0, 0, 1);
		queue_step(-3, -3, 0, 0);
		queue_step(3, 3, 0, 0);
		wait_idle();

		// Random road phases, one per setting
		load_gains(KP_LEFT_RST, KP_RIGHT_RST, KI_T_RST, CFG_DATA_W'(OUT_LIMIT_RST));
		queue_road_ticks(ROAD_TICKS);
		wait_idle();

		load_gains(CFG_DATA_W'($urandom_range(0, 400)), CFG_DATA_W'($urandom_range(0, 400)),
			CFG_DATA_W'($urandom_range(0, 32)), 1023);
		queue_road_ticks(ROAD_TICKS);
		wait_idle();

		load_gains(4095, 4095, 4095, 1023);
		queue_road_ticks(ROAD_TICKS);
		wait_idle();

		load_gains(CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 4095)),
			CFG_DATA_W'($urandom_range(0, 4095)), CFG_DATA_W'($urandom_range(0, 1023)));
		queue_road_ticks(ROAD_TICKS);
		wait_idle();

		// Back-to-back ticks while the receiver holds off: the pipe fills and stalls input
		load_gains(CFG_DATA_W'($urandom_range(0, 600)), CFG_DATA_W'($urandom_range(0, 600)),
			CFG_DATA_W'($urandom_range(0, 64)), CFG_DATA_W'($urandom_range(1, 1023)));
		tick_gapless = 1'b1;
		queue_road_ticks(ROAD_TICKS);
		stalls_asked++;
		wait_idle();
		tick_gapless = 1'b0;

		load_gains(0, CFG_DATA_W'($urandom_range(0, 4095)), 0,
			CFG_DATA_W'($urandom_range(1, 8)));
		queue_road_ticks(ROAD_TICKS);
		wait_idle();

		// Sustained full-scale error of opposite sign on each wheel winds both integrators
		// up hard and holds the drive on its clamp, then reverse error unwinds them
		load_gains(KP_LEFT_RST, KP_RIGHT_RST, KI_T_RST, CFG_DATA_W'(OUT_LIMIT_RST));
		tick_gapless = 1'b1;
		for (int i = 0; i < SAT_TICKS; i++)
			queue_step(-32768, 32767, 127, -128);
		for (int i = 0; i < UNWIND; i++)
			queue_step(32767, -32768, -128, 127);
		wait_idle();
		tick_gapless = 1'b0;

		repeat (FINAL_TAIL) @(posedge clk);
		if (expected_duty.size() != 0)
			note_mismatch("duty beats never returned", expected_duty.size(), 0);

		$display("%0d tick beats in, %0d duty beats out, across %0d gain/limit settings",
			ticks_taken, duty_beats, settings_used);
		$display("%0d register writes, integrator pinned at its rail on %0d wheel updates",
			regs_written, sum_pinned);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timed out after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
